### design/nbs_pkg.sv
package nbs_pkg;

  localparam int MAX_BOXES_DEF  = 64;
  localparam int COORD_BITS_DEF = 12;

  localparam int KEPT_POS_BITS  = 13;
  localparam int KEPT_SIZE_BITS = 12;

  // operand width of the constant dividers, covers coordinates up to 16 bits
  localparam int DIV_BITS = 20;

  localparam logic [DIV_BITS-1:0] RECIP_10  = DIV_BITS'(838861);
  localparam int                  SHIFT_10  = 23;
  localparam logic [DIV_BITS-1:0] RECIP_100 = DIV_BITS'(671089);
  localparam int                  SHIFT_100 = 26;

  localparam logic [DIV_BITS-1:0] RND_10  = DIV_BITS'(5);
  localparam logic [DIV_BITS-1:0] RND_100 = DIV_BITS'(50);

  localparam logic [DIV_BITS-1:0] KEPT_SIZE_MAX = DIV_BITS'((1 << KEPT_SIZE_BITS) - 1);

  typedef struct packed {
    logic [KEPT_POS_BITS-1:0]  x;
    logic [KEPT_POS_BITS-1:0]  y;
    logic [KEPT_SIZE_BITS-1:0] w;
    logic [KEPT_SIZE_BITS-1:0] h;
  } kept_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_FETCH,
    S_CAND,
    S_SCAN,
    S_DEC,
    S_SHRK,
    S_FIN
  } state_t;

endpackage

### design/nbs_shrink.sv
module nbs_shrink
  import nbs_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic [COORD_BITS-1:0] box_x,
  input  logic [COORD_BITS-1:0] box_y,
  input  logic [COORD_BITS:0]   box_width,
  input  logic [COORD_BITS:0]   box_height,
  output kept_t                 kept
);

  logic [DIV_BITS-1:0]   v_xoff, v_w, v_yoff, v_h;
  logic [2*DIV_BITS-1:0] p_xoff, p_w, p_yoff, p_h;
  logic [DIV_BITS-1:0]   q_xoff_r, q_w_r, q_yoff_r, q_h_r;
  logic [DIV_BITS:0]     sum_x, sum_y;

  assign v_xoff = DIV_BITS'(box_width) + RND_10;
  assign v_w    = DIV_BITS'({box_width, 3'b000}) + RND_10;
  assign v_h    = DIV_BITS'({box_height, 3'b000}) + RND_10;
  assign v_yoff = DIV_BITS'({box_height, 3'b000}) - DIV_BITS'(box_height) + RND_100;

  assign p_xoff = {{DIV_BITS{1'b0}}, v_xoff} * {{DIV_BITS{1'b0}}, RECIP_10};
  assign p_w    = {{DIV_BITS{1'b0}}, v_w}    * {{DIV_BITS{1'b0}}, RECIP_10};
  assign p_h    = {{DIV_BITS{1'b0}}, v_h}    * {{DIV_BITS{1'b0}}, RECIP_10};
  assign p_yoff = {{DIV_BITS{1'b0}}, v_yoff} * {{DIV_BITS{1'b0}}, RECIP_100};

  always_ff @(posedge clk) begin
    q_xoff_r <= DIV_BITS'(p_xoff >> SHIFT_10);
    q_w_r    <= DIV_BITS'(p_w >> SHIFT_10);
    q_h_r    <= DIV_BITS'(p_h >> SHIFT_10);
    q_yoff_r <= DIV_BITS'(p_yoff >> SHIFT_100);
  end

  assign sum_x = (DIV_BITS+1)'(box_x) + {1'b0, q_xoff_r};
  assign sum_y = (DIV_BITS+1)'(box_y) + {1'b0, q_yoff_r};

  always_comb begin
    kept.x = sum_x[KEPT_POS_BITS-1:0];
    kept.y = sum_y[KEPT_POS_BITS-1:0];
    kept.w = (q_w_r > KEPT_SIZE_MAX) ? '1 : q_w_r[KEPT_SIZE_BITS-1:0];
    kept.h = (q_h_r > KEPT_SIZE_MAX) ? '1 : q_h_r[KEPT_SIZE_BITS-1:0];
  end

endmodule

### design/nested_box_suppression.sv
// Load: one item per cycle; in_ready is low from the closing item until the set is emitted.
// Check: each rectangle is fetched, captured, scanned against all N entries and decided;
// each survivor then takes a shrink step, and one closing step ends the set.
// Each survivor is held until the next one is found, so the first result is emitted only
// when a second survivor is found or the set closes; output stalls can hold the check.
// Reset clears the control state, counters and output valid; the store is not cleared.
module nested_box_suppression
  import nbs_pkg::*;
#(
  parameter int MAX_BOXES  = MAX_BOXES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COORD_BITS-1:0]     in_box_x,
  input  logic [COORD_BITS-1:0]     in_box_y,
  input  logic [COORD_BITS:0]       in_box_width,
  input  logic [COORD_BITS:0]       in_box_height,
  input  logic                      in_final_box,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [KEPT_POS_BITS-1:0]  out_kept_x,
  output logic [KEPT_POS_BITS-1:0]  out_kept_y,
  output logic [KEPT_SIZE_BITS-1:0] out_kept_width,
  output logic [KEPT_SIZE_BITS-1:0] out_kept_height,
  output logic                      out_end_of_run,
  output logic                      out_set_empty,
  output logic                      out_capacity_exceeded
);

  localparam int IDX_BITS  = $clog2(MAX_BOXES);
  localparam int CNT_BITS  = $clog2(MAX_BOXES + 1);
  localparam int SIZE_BITS = COORD_BITS + 1;
  localparam int REC_BITS  = 2 * COORD_BITS + 2 * SIZE_BITS;
  localparam int EDGE_BITS = COORD_BITS + 2;
  localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_BOXES);
  localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);

  logic [REC_BITS-1:0] mem [MAX_BOXES];
  logic [REC_BITS-1:0] rd_data_r;
  logic [IDX_BITS-1:0] rd_addr;
  logic                wr_en;

  state_t state_r, state_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic [CNT_BITS-1:0] i_r, i_nxt;
  logic [CNT_BITS-1:0] j_r, j_nxt;
  logic [CNT_BITS-1:0] j_inc;
  logic                ovf_r, ovf_nxt;
  logic                drop_r, drop_nxt;
  logic                pend_v_r, pend_v_nxt;
  kept_t               pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  kept_t               out_r, out_nxt;
  logic                out_eor_r, out_eor_nxt;
  logic                out_empty_r, out_empty_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic [COORD_BITS-1:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic [SIZE_BITS-1:0]  cw_r, ch_r, cw_nxt, ch_nxt;
  logic [COORD_BITS-1:0] rx, ry;
  logic [SIZE_BITS-1:0]  rw, rh;

  logic  in_acc, out_free, last_i, last_j, hit;
  kept_t kept;

  assign in_ready = (state_r == S_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign last_i   = (i_r == count_r - CNT_ONE);
  assign last_j   = (j_r == count_r - CNT_ONE);
  assign j_inc    = j_r + CNT_ONE;
  assign wr_en    = in_acc && (count_r < CNT_MAX);

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_BITS-1:0]] <= {in_box_x, in_box_y, in_box_width, in_box_height};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    case (state_r)
      S_FETCH: rd_addr = i_r[IDX_BITS-1:0];
      S_SCAN:  rd_addr = j_inc[IDX_BITS-1:0];
      default: rd_addr = '0;
    endcase
  end

  assign {rx, ry, rw, rh} = rd_data_r;

  assign hit = (j_r != i_r) && (cx_r >= rx) && (cy_r >= ry) &&
               (EDGE_BITS'(cx_r) + EDGE_BITS'(cw_r) <= EDGE_BITS'(rx) + EDGE_BITS'(rw)) &&
               (EDGE_BITS'(cy_r) + EDGE_BITS'(ch_r) <= EDGE_BITS'(ry) + EDGE_BITS'(rh));

  nbs_shrink #(
    .COORD_BITS (COORD_BITS)
  ) u_shrink (
    .clk        (clk),
    .box_x      (cx_r),
    .box_y      (cy_r),
    .box_width  (cw_r),
    .box_height (ch_r),
    .kept       (kept)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (in_valid && in_final_box) state_nxt = S_FETCH;
      end
      S_FETCH: state_nxt = S_CAND;
      S_CAND:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (last_j) state_nxt = S_DEC;
      end
      S_DEC: begin
        if (!drop_r) begin
          state_nxt = S_SHRK;
        end else begin
          state_nxt = last_i ? S_FIN : S_FETCH;
        end
      end
      S_SHRK: begin
        if (!pend_v_r || out_free) state_nxt = last_i ? S_FIN : S_FETCH;
      end
      S_FIN: begin
        if (out_free) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    drop_nxt      = drop_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cw_nxt        = cw_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    out_eor_nxt   = out_eor_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;
    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (count_r < CNT_MAX) begin
            count_nxt = count_r + CNT_ONE;
          end else begin
            ovf_nxt = 1'b1;
          end
          i_nxt = '0;
        end
      end
      S_CAND: begin
        {cx_nxt, cy_nxt, cw_nxt, ch_nxt} = rd_data_r;
        j_nxt    = '0;
        drop_nxt = 1'b0;
      end
      S_SCAN: begin
        drop_nxt = drop_r || hit;
        j_nxt    = j_inc;
      end
      S_DEC: begin
        if (drop_r) i_nxt = i_r + CNT_ONE;
      end
      S_SHRK: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = pend_r;
            out_eor_nxt   = 1'b0;
            out_empty_nxt = 1'b0;
            out_ovf_nxt   = ovf_r;
          end
          pend_nxt   = kept;
          pend_v_nxt = 1'b1;
          i_nxt      = i_r + CNT_ONE;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pend_v_r ? pend_r : '0;
          out_eor_nxt   = 1'b1;
          out_empty_nxt = !pend_v_r;
          out_ovf_nxt   = ovf_r;
          pend_v_nxt    = 1'b0;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      drop_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      drop_r      <= drop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r      <= pend_nxt;
    out_r       <= out_nxt;
    out_eor_r   <= out_eor_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    cw_r        <= cw_nxt;
    ch_r        <= ch_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_kept_x            = out_r.x;
  assign out_kept_y            = out_r.y;
  assign out_kept_width        = out_r.w;
  assign out_kept_height       = out_r.h;
  assign out_end_of_run        = out_eor_r;
  assign out_set_empty         = out_empty_r;
  assign out_capacity_exceeded = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("box count beyond capacity");

  a_check_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_LOAD |-> count_r != '0)
    else $error("check running on an empty set");

  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> (j_r < count_r) && (i_r < count_r))
    else $error("scan index out of range");

  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |-> !pend_v_r)
    else $error("pending survivor left over after a set");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_eor_r && (out_r == '0))
    else $error("empty result not last or not zero");

endmodule
